@@ rtl/core/mrr_pkg.sv @@
// mrr_pkg: shared types and constants of the modbus rtu response receiver
// payload structs, operation and register codes, command type between front and back
// no dependencies
package mrr_pkg;

    // input operation codes
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_BYTE  = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_EXPECTED_ADDRESS = 2'd0;
    localparam logic [1:0] CFG_DATA_WORDS       = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT_TICKS    = 2'd2;
    localparam int unsigned CFG_DATA_W = 16;

    // result status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_EXCEPTION = 2'd1;
    localparam logic [1:0] STATUS_TOO_SHORT = 2'd2;
    localparam logic [1:0] STATUS_CRC_ERROR = 2'd3;

    // frame constants
    localparam logic [6:0]  MAX_DATA_WORDS   = 7'd125;
    localparam logic [15:0] CRC_INIT         = 16'hFFFF;
    localparam logic [15:0] CRC_POLY         = 16'hA001;
    localparam logic [7:0]  MIN_FRAME_BYTES  = 8'd6;
    localparam logic [7:0]  EXC_DEFAULT_CODE = 8'd3;
    localparam logic [7:0]  FC_WRITE_COIL    = 8'd5;
    localparam logic [7:0]  FC_WRITE_REG     = 8'd6;
    localparam logic [7:0]  FC_WRITE_COILS   = 8'd15;
    localparam logic [7:0]  FC_WRITE_REGS    = 8'd16;

    // reset values of the configuration registers
    localparam logic [7:0]  RST_EXPECTED_ADDRESS = 8'd0;
    localparam logic [6:0]  RST_DATA_WORDS       = 7'd1;
    localparam logic [15:0] RST_TIMEOUT_TICKS    = 16'd10;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic       byte_valid;
        logic [7:0] byte_value;
        logic [7:0] byte_index;
        logic       done_res;
        logic [1:0] status;
        logic [7:0] exception_code;
    } out_item_t;

    typedef enum logic [1:0] {
        CMD_START,
        CMD_BYTE,
        CMD_TICK
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] data;
    } cmd_t;

endpackage

@@ rtl/core/mrr_fifo.sv @@
// mrr_fifo: small register queue used between the stages of the receiver
// generic width and depth, first-word-fall-through read
// no dependencies
module mrr_fifo #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ rtl/core/mrr_front.sv @@
// mrr_front: accepts input transactions and classifies them into commands
// unused operation codes are dropped here and never reach the back end
// depends on mrr_pkg
module mrr_front (
    input  logic              push,
    input  mrr_pkg::in_item_t item,
    output logic              full,
    input  logic              cmd_full,
    output logic              cmd_push,
    output mrr_pkg::cmd_t     cmd
);

    assign full = cmd_full;

    always_comb
    begin
        cmd.data = item.rx_byte;
        cmd.kind = mrr_pkg::CMD_TICK;
        cmd_push = push;
        case (item.operation)
            mrr_pkg::OP_START: cmd.kind = mrr_pkg::CMD_START;
            mrr_pkg::OP_BYTE:  cmd.kind = mrr_pkg::CMD_BYTE;
            mrr_pkg::OP_TICK:  cmd.kind = mrr_pkg::CMD_TICK;
            default:           cmd_push = 1'b0;
        endcase
    end

endmodule

@@ rtl/core/mrr_back.sv @@
// mrr_back: frame state machine, incremental crc-16 and result generation
// holds the configuration registers; runs one command per cycle while the result queue has room
// depends on mrr_pkg
module mrr_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [1:0]                 cfg_index,
    input  logic [mrr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                       cmd_empty,
    input  mrr_pkg::cmd_t              cmd,
    output logic                       cmd_pop,
    input  logic                       res_full,
    output logic                       res_push,
    output mrr_pkg::out_item_t         res
);

    logic [7:0]  expected_address_reg;
    logic [6:0]  data_words_reg;
    logic [15:0] timeout_ticks_reg;

    logic        active_reg, active_next;
    logic [7:0]  byte_count_reg, byte_count_next;
    logic [7:0]  function_byte_reg, function_byte_next;
    logic        long_header_reg, long_header_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] idle_ticks_reg, idle_ticks_next;

    logic [15:0] crc_byte;
    logic [7:0]  count_inc;
    logic [6:0]  words;
    logic [8:0]  frame_len;
    logic [7:0]  limit;
    logic [15:0] tick_limit;
    logic        run;

    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ mrr_pkg::CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    assign run     = !cmd_empty && !res_full;
    assign cmd_pop = run;

    assign crc_byte   = crc_update(crc_reg, cmd.data);
    assign count_inc  = byte_count_reg + 8'd1;
    assign words      = (data_words_reg > mrr_pkg::MAX_DATA_WORDS) ? mrr_pkg::MAX_DATA_WORDS
                                                                   : data_words_reg;
    assign frame_len  = {1'b0, words, 1'b0} + (long_header_next ? 9'd6 : 9'd5);
    assign limit      = frame_len[8] ? 8'd255 : frame_len[7:0];
    assign tick_limit = (timeout_ticks_reg == 16'd0) ? 16'd1 : timeout_ticks_reg;

    always_comb
    begin
        active_next        = active_reg;
        byte_count_next    = byte_count_reg;
        function_byte_next = function_byte_reg;
        long_header_next   = long_header_reg;
        crc_next           = crc_reg;
        idle_ticks_next    = idle_ticks_reg;
        res_push           = 1'b0;
        res                = '0;
        if (run)
        begin
            case (cmd.kind)
                mrr_pkg::CMD_START:
                begin
                    active_next        = 1'b1;
                    byte_count_next    = '0;
                    function_byte_next = '0;
                    long_header_next   = 1'b0;
                    crc_next           = mrr_pkg::CRC_INIT;
                    idle_ticks_next    = '0;
                end
                mrr_pkg::CMD_BYTE:
                begin
                    if (active_reg)
                    begin
                        idle_ticks_next = '0;
                        // leading bytes are dropped until the slave address shows up
                        if (byte_count_reg != 8'd0 || cmd.data == expected_address_reg)
                        begin
                            res_push        = 1'b1;
                            res.byte_valid  = 1'b1;
                            res.byte_value  = cmd.data;
                            res.byte_index  = byte_count_reg;
                            crc_next        = crc_byte;
                            byte_count_next = count_inc;
                            if (count_inc == 8'd2)
                            begin
                                function_byte_next = cmd.data;
                            end
                            if (count_inc == 8'd3 && function_byte_reg[7])
                            begin
                                active_next        = 1'b0;
                                res.done_res       = 1'b1;
                                res.status         = mrr_pkg::STATUS_EXCEPTION;
                                res.exception_code = (cmd.data == 8'd0) ? mrr_pkg::EXC_DEFAULT_CODE
                                                                        : cmd.data;
                            end
                            else
                            begin
                                if (count_inc == 8'd3 &&
                                    (function_byte_reg == mrr_pkg::FC_WRITE_COIL  ||
                                     function_byte_reg == mrr_pkg::FC_WRITE_REG   ||
                                     function_byte_reg == mrr_pkg::FC_WRITE_COILS ||
                                     function_byte_reg == mrr_pkg::FC_WRITE_REGS))
                                begin
                                    long_header_next = 1'b1;
                                end
                                if (count_inc >= limit)
                                begin
                                    active_next  = 1'b0;
                                    res.done_res = 1'b1;
                                    if (count_inc < mrr_pkg::MIN_FRAME_BYTES)
                                        res.status = mrr_pkg::STATUS_TOO_SHORT;
                                    else if (crc_byte == 16'd0)
                                        res.status = mrr_pkg::STATUS_OK;
                                    else
                                        res.status = mrr_pkg::STATUS_CRC_ERROR;
                                end
                            end
                        end
                    end
                end
                mrr_pkg::CMD_TICK:
                begin
                    if (active_reg)
                    begin
                        if (idle_ticks_reg != 16'hFFFF)
                        begin
                            idle_ticks_next = idle_ticks_reg + 16'd1;
                        end
                        if (idle_ticks_next >= tick_limit)
                        begin
                            active_next  = 1'b0;
                            res_push     = 1'b1;
                            res.done_res = 1'b1;
                            if (byte_count_reg < mrr_pkg::MIN_FRAME_BYTES)
                                res.status = mrr_pkg::STATUS_TOO_SHORT;
                            else if (crc_reg == 16'd0)
                                res.status = mrr_pkg::STATUS_OK;
                            else
                                res.status = mrr_pkg::STATUS_CRC_ERROR;
                        end
                    end
                end
                default:
                begin
                    active_next = active_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_address_reg <= mrr_pkg::RST_EXPECTED_ADDRESS;
            data_words_reg       <= mrr_pkg::RST_DATA_WORDS;
            timeout_ticks_reg    <= mrr_pkg::RST_TIMEOUT_TICKS;
            active_reg           <= 1'b0;
            byte_count_reg       <= '0;
            function_byte_reg    <= '0;
            long_header_reg      <= 1'b0;
            crc_reg              <= mrr_pkg::CRC_INIT;
            idle_ticks_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    mrr_pkg::CFG_EXPECTED_ADDRESS: expected_address_reg <= cfg_data[7:0];
                    mrr_pkg::CFG_DATA_WORDS:       data_words_reg       <= cfg_data[6:0];
                    mrr_pkg::CFG_TIMEOUT_TICKS:    timeout_ticks_reg    <= cfg_data;
                    default:                       data_words_reg       <= data_words_reg;
                endcase
            end
            active_reg        <= active_next;
            byte_count_reg    <= byte_count_next;
            function_byte_reg <= function_byte_next;
            long_header_reg   <= long_header_next;
            crc_reg           <= crc_next;
            idle_ticks_reg    <= idle_ticks_next;
        end
    end

endmodule

@@ rtl/core/modbus_rtu_response_receiver.sv @@
// modbus_rtu_response_receiver: top level of the modbus rtu response receiver
// joins front end, command queue, back end and result queue
// depends on mrr_pkg, mrr_fifo, mrr_front, mrr_back
//
// input channel: push/full with item (operation, rx_byte); start, received byte
// or timer tick. a transaction completes on a rising edge with push high, full low.
// result channel: empty/pop with result; the oldest result is shown while empty
// is low and leaves on a rising edge with pop high.
// a start arms reception; bytes before the slave address are dropped; every
// stored byte gives one result with its index, and the last one also carries
// done_res with the frame status. a timeout gives a done-only result.
// configuration: cfg_we, cfg_index, cfg_data, to be written only while idle; the block does not enforce it.
// path: a taken item is registered in the command queue, the back end turns it into any
// result, which is registered in the result queue and can be popped from there.
// throughput: one item per cycle while the result queue has room, set by the
// one-command-per-cycle back end with the crc-16 byte update done combinationally.
// stalls: when pop stays low the result queue fills, the back end holds, then the
// command queue fills and full rises; nothing is lost.
// reset: queues empty, receiver idle, registers at their reset values.
module modbus_rtu_response_receiver #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  mrr_pkg::in_item_t              item,
    output logic                           full,
    output logic                           empty,
    input  logic                           pop,
    output mrr_pkg::out_item_t             result,
    input  logic                           cfg_we,
    input  logic [1:0]                     cfg_index,
    input  logic [mrr_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int unsigned CMD_W = $bits(mrr_pkg::cmd_t);
    localparam int unsigned RES_W = $bits(mrr_pkg::out_item_t);

    logic               cmd_push, cmd_full, cmd_empty, cmd_pop;
    mrr_pkg::cmd_t      cmd_in, cmd_out;
    logic               res_push, res_full;
    mrr_pkg::out_item_t res_in;

    mrr_front u_front (
        .push     (push),
        .item     (item),
        .full     (full),
        .cmd_full (cmd_full),
        .cmd_push (cmd_push),
        .cmd      (cmd_in)
    );

    mrr_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (cmd_in),
        .full      (cmd_full),
        .pop       (cmd_pop),
        .pop_data  (cmd_out),
        .empty     (cmd_empty)
    );

    mrr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_empty (cmd_empty),
        .cmd       (cmd_out),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    mrr_fifo #(
        .WIDTH (RES_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_in),
        .full      (res_full),
        .pop       (pop),
        .pop_data  (result),
        .empty     (empty)
    );

endmodule

@@ rtl/core/mrr_checker.sv @@
// mrr_checker: port-level assertions for the modbus rtu response receiver
// bound to the top level below
// depends on mrr_pkg
module mrr_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               empty,
    input logic               pop,
    input mrr_pkg::out_item_t result
);

    // every result carries a byte, a done report or both
    a_result_has_content: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (result.byte_valid || result.done_res))
        else $error("result with neither byte nor done");

    // status is only reported with done
    a_status_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.done_res) |-> (result.status == mrr_pkg::STATUS_OK))
        else $error("status without done");

    // exception code only on an exception report, and then never zero
    a_exception_code: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((result.status == mrr_pkg::STATUS_EXCEPTION && result.done_res) ?
                    (result.exception_code != 8'd0) : (result.exception_code == 8'd0)))
        else $error("exception code mismatch");

    // a waiting result stays in place until taken
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting result changed");

endmodule

bind modbus_rtu_response_receiver mrr_checker u_mrr_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);
